/* sv/smtq_pkg.sv */
// Package: types, constants and codes for the sorted multi-timer queue.
`timescale 1ns / 1ps
package smtq_pkg;
    localparam int NUM_SLOTS = 32;
    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [31:0] NEVER = 32'hffff_ffff;
    localparam logic [31:0] COUNT_MAX = 32'hffff_fffe;
    localparam int FIRE_LIMIT = 31;

    typedef logic [SW-1:0] t_slot;
    typedef logic [1:0] t_status;
    localparam t_status ST_FREE = 2'd0;
    localparam t_status ST_ALLOC = 2'd1;
    localparam t_status ST_RUN = 2'd2;

    typedef enum logic [2:0] {
        ACT_TICK = 3'd0, ACT_ALLOC = 3'd1, ACT_FREE = 3'd2, ACT_SET = 3'd3,
        ACT_START = 3'd4, ACT_CANCEL = 3'd5, ACT_MARK = 3'd6, ACT_CGROUP = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        KIND_MSG = 3'd0, KIND_TASK = 3'd1, KIND_ALLOC = 3'd2,
        KIND_CANCEL = 3'd3, KIND_DONE = 3'd4
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_TICK_RD, S_TICK_CHK, S_TASK, S_ALLOC_SCAN,
        S_STOP, S_SUCC_RD, S_SUCC_CHK, S_HEAD_RD, S_HEAD_CHK, S_UNL_RD, S_UNL_CHK,
        S_POST_STOP, S_START_EXP, S_INS_RD, S_INS_CHK, S_INS_LINK, S_GRP_SCAN,
        S_GRP_RD, S_GRP_CHK, S_DONE
    } t_state;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        t_slot       slot;
        logic [7:0]  target;
        logic [31:0] data;
        logic        ok;
        logic        last;
    } t_result;
endpackage

/* sv/smtq_ram.sv */
// Generic RAM with one write port and one read port, with registered read.
`timescale 1ns / 1ps
module smtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* sv/sorted_multi_timer_queue.sv */
// Top level: timer pool, sorted expiry list and command sequencer.
//
// channel  direction  handshake               payload
// command  in         start / busy            action slot timeout target_id message_data
// config   in         i_cfg_valid/o_cfg_ready i_cfg_data (task switch slot)
// result   out        o_strobe                kind slot target data ok last
//
// A tick walks the list from the head and fires due timers in order. Free, cancel and start
// stop a running slot by unlinking it at the head or after walking its predecessors;
// start then inserts the slot by comparing list entries in order. Group cancel scans
// marked candidates, stopping each whose target matches. The last beat shows once idle.
// Reset is synchronous; the list then holds only the sentinel. Results cannot stall.
`timescale 1ns / 1ps
module sorted_multi_timer_queue
    import smtq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [4:0]  i_slot,
    input  logic [31:0] i_timeout,
    input  logic [7:0]  i_target_id,
    input  logic signed [31:0] i_message_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [4:0]  o_result_slot,
    output logic [7:0]  o_result_target,
    output logic signed [31:0] o_result_data,
    output logic        o_ok,
    output logic        o_last
);
    t_state r_state, n_state;
    t_action r_act;
    t_slot r_s, r_cur, r_prev, r_succ;
    logic [SW:0] r_i;
    logic r_sval;
    logic [31:0] r_timeout, r_data, r_tick, r_due, r_exp;
    logic [7:0] r_tgt;
    t_slot r_head;
    logic [5:0] r_task;
    t_status r_stat [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_mark;
    logic [5:0] r_fired;
    logic r_ts, r_ok, r_after_first;
    t_result r_res, n_res;

    // memories: expiry, link, target, data
    logic e_we, l_we, t_we;
    t_slot e_wa, l_wa, t_wa, e_ra, l_ra, t_ra;
    logic [31:0] e_wd, e_rd, d_rd;
    t_slot l_wd, l_rd;
    logic [7:0] t_rd;

    smtq_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_exp (.i_clk, .i_we(e_we), .i_waddr(e_wa),
        .i_wdata(e_wd), .i_raddr(e_ra), .o_rdata(e_rd));
    smtq_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_lnk (.i_clk, .i_we(l_we), .i_waddr(l_wa),
        .i_wdata(l_wd), .i_raddr(l_ra), .o_rdata(l_rd));
    smtq_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS)) u_tgt (.i_clk, .i_we(t_we), .i_waddr(t_wa),
        .i_wdata(r_tgt), .i_raddr(t_ra), .o_rdata(t_rd));
    smtq_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_dat (.i_clk, .i_we(t_we), .i_waddr(t_wa),
        .i_wdata(r_data), .i_raddr(t_ra), .o_rdata(d_rd));

    assign e_wa = r_s;
    assign t_wa = r_s;
    assign e_ra = r_cur;
    assign l_ra = r_cur;
    assign t_ra = r_cur;

    // expiry reads: slot 0 always NEVER
    logic r_e0;
    logic [31:0] exp_q;
    assign exp_q = r_e0 ? NEVER : e_rd;

    always_ff @(posedge i_clk) begin
        r_e0 <= (r_cur == '0);
    end

    logic [32:0] sum;
    assign sum = {1'b0, r_timeout} + {1'b0, r_tick};
    logic has_task;
    assign has_task = (r_task < 6'(NUM_SLOTS));

    logic tick_fire, task_hit;
    assign tick_fire = (r_fired < 6'(FIRE_LIMIT)) && (exp_q <= r_tick);
    assign task_hit = has_task && (6'(r_cur) == r_task);

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = !busy && !start;

    // group scan: lowest marked, non-free slot at or above r_i
    logic grp_hit;
    t_slot grp_slot;
    always_comb begin
        grp_hit = 1'b0;
        grp_slot = '0;
        for (int k = NUM_SLOTS - 1; k >= 1; k--) begin
            if ((SW+1)'(k) >= r_i && r_stat[k] != ST_FREE && r_mark[k]) begin
                grp_hit = 1'b1;
                grp_slot = t_slot'(k);
            end
        end
    end
    logic alloc_hit;
    t_slot alloc_slot;
    always_comb begin
        alloc_hit = 1'b0;
        alloc_slot = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_stat[k] == ST_FREE) begin
                alloc_hit = 1'b1;
                alloc_slot = t_slot'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (start) n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (r_act)
                    ACT_TICK:   n_state = (r_due <= r_tick) ? S_TICK_RD : S_TASK;
                    ACT_ALLOC:  n_state = S_ALLOC_SCAN;
                    ACT_CGROUP: n_state = S_GRP_SCAN;
                    ACT_FREE, ACT_CANCEL:
                        n_state = r_sval ? S_STOP : S_DONE;
                    ACT_START:
                        n_state = (r_sval && r_stat[r_s] != ST_FREE) ? S_STOP : S_DONE;
                    ACT_SET, ACT_MARK:
                        n_state = S_DONE;
                endcase
            end
            S_TICK_RD:  n_state = S_TICK_CHK;
            S_TICK_CHK: n_state = tick_fire ? S_TICK_RD : S_TASK;
            S_TASK:     n_state = S_DONE;
            S_ALLOC_SCAN: n_state = S_IDLE;
            S_STOP:     n_state = (r_stat[r_s] == ST_RUN) ? S_SUCC_RD : S_POST_STOP;
            S_SUCC_RD:  n_state = S_SUCC_CHK;
            S_SUCC_CHK: n_state = (r_head == r_s) ? S_HEAD_RD : S_UNL_RD;
            S_HEAD_RD:  n_state = S_HEAD_CHK;
            S_HEAD_CHK: n_state = S_POST_STOP;
            S_UNL_RD:   n_state = S_UNL_CHK;
            S_UNL_CHK:  n_state = (l_rd == r_s) ? S_POST_STOP : S_UNL_RD;
            S_POST_STOP: begin
                priority if (r_act == ACT_CGROUP) n_state = S_GRP_SCAN;
                else if (r_act == ACT_START) n_state = S_START_EXP;
                else n_state = S_DONE;
            end
            S_START_EXP: n_state = S_INS_RD;
            S_INS_RD:   n_state = S_INS_CHK;
            S_INS_CHK: begin
                if (r_exp <= exp_q) n_state = r_after_first ? S_INS_LINK : S_DONE;
                else n_state = S_INS_RD;
            end
            S_INS_LINK: n_state = S_DONE;
            S_GRP_SCAN: n_state = grp_hit ? S_GRP_RD : S_DONE;
            S_GRP_RD:   n_state = S_GRP_CHK;
            S_GRP_CHK:  n_state = (t_rd == r_tgt) ? S_STOP : S_GRP_SCAN;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        e_we = 1'b0; e_wd = r_exp;
        l_we = 1'b0; l_wa = r_s; l_wd = r_cur;
        t_we = 1'b0;
        n_res = '0;
        unique case (r_state)
            S_DISPATCH: t_we = (r_act == ACT_SET) && r_sval;
            S_TICK_CHK: if (tick_fire && !task_hit) begin
                n_res.valid = 1'b1; n_res.kind = KIND_MSG; n_res.slot = r_cur;
                n_res.target = t_rd; n_res.data = d_rd;
            end
            S_TASK: if (r_ts) begin
                n_res.valid = 1'b1; n_res.kind = KIND_TASK; n_res.slot = t_slot'(r_task);
            end
            S_ALLOC_SCAN: begin
                n_res.valid = 1'b1; n_res.kind = KIND_ALLOC; n_res.last = 1'b1;
                n_res.ok = alloc_hit; n_res.slot = alloc_slot;
            end
            S_UNL_CHK: if (l_rd == r_s) begin
                l_we = 1'b1; l_wa = r_cur; l_wd = r_succ;
            end
            S_START_EXP: e_we = 1'b1;
            S_INS_CHK: if (r_exp <= exp_q) begin
                l_we = 1'b1; l_wa = r_s; l_wd = r_cur;
            end
            S_INS_LINK: begin
                l_we = 1'b1; l_wa = r_prev; l_wd = r_s;
            end
            S_DONE: begin
                n_res.valid = 1'b1; n_res.last = 1'b1;
                n_res.kind = (r_act == ACT_CANCEL) ? KIND_CANCEL : KIND_DONE;
                n_res.ok = (r_act == ACT_CANCEL) && r_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tick <= '0;
            r_due <= NEVER;
            r_head <= '0;
            r_cur <= '0;
            r_mark <= '0;
            r_task <= 6'd32;
            r_res <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) r_stat[k] <= (k == 0) ? ST_RUN : ST_FREE;
        end else begin
            r_state <= n_state;
            r_res <= n_res;
            if (i_cfg_valid && o_cfg_ready) r_task <= i_cfg_data;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_act <= t_action'(i_action);
                    r_s <= t_slot'(i_slot);
                    r_sval <= (i_slot != 5'd0) && (6'(i_slot) < 6'(NUM_SLOTS));
                    r_timeout <= i_timeout;
                    r_tgt <= i_target_id;
                    r_data <= i_message_data;
                    r_ok <= 1'b0;
                    r_ts <= 1'b0;
                    r_fired <= '0;
                    r_i <= (SW+1)'(1);
                    if (t_action'(i_action) == ACT_TICK && r_tick < COUNT_MAX)
                        r_tick <= r_tick + 32'd1;
                end
                S_DISPATCH: begin
                    r_cur <= r_head;
                    if (r_act == ACT_MARK && r_sval) r_mark[r_s] <= 1'b1;
                end
                S_TICK_CHK: begin
                    if (tick_fire) begin
                        r_stat[r_cur] <= ST_ALLOC;
                        if (task_hit) r_ts <= 1'b1;
                        r_cur <= l_rd;
                        r_fired <= r_fired + 6'd1;
                    end else begin
                        r_head <= r_cur;
                        r_due <= exp_q;
                    end
                end
                S_ALLOC_SCAN: if (alloc_hit) begin
                    r_stat[alloc_slot] <= ST_ALLOC;
                    r_mark[alloc_slot] <= 1'b0;
                end
                S_STOP: r_cur <= r_s;
                S_SUCC_CHK: begin
                    r_succ <= l_rd;
                    r_cur <= (r_head == r_s) ? l_rd : r_head;
                end
                S_HEAD_CHK: begin
                    r_head <= r_succ;
                    r_due <= exp_q;
                end
                S_UNL_CHK: if (l_rd != r_s) r_cur <= l_rd;
                S_POST_STOP: begin
                    if (r_act == ACT_FREE || r_act == ACT_CGROUP) r_stat[r_s] <= ST_FREE;
                    else if (r_stat[r_s] == ST_RUN) r_stat[r_s] <= ST_ALLOC;
                    if (r_stat[r_s] == ST_RUN) r_ok <= 1'b1;
                    if (r_act == ACT_CGROUP) r_i <= (SW+1)'(r_s) + (SW+1)'(1);
                    r_exp <= sum[32] ? NEVER : sum[31:0];
                end
                S_START_EXP: begin
                    r_stat[r_s] <= ST_RUN;
                    r_cur <= r_head;
                    r_after_first <= 1'b0;
                end
                S_INS_CHK: begin
                    if (r_exp <= exp_q) begin
                        if (!r_after_first) begin
                            r_head <= r_s;
                            r_due <= r_exp;
                        end
                    end else begin
                        r_after_first <= 1'b1;
                        r_prev <= r_cur;
                        r_cur <= l_rd;
                    end
                end
                S_GRP_SCAN: if (grp_hit) begin
                    r_s <= grp_slot;
                    r_cur <= grp_slot;
                end
                S_GRP_CHK: if (t_rd != r_tgt) r_i <= (SW+1)'(r_s) + (SW+1)'(1);
                default: ;
            endcase
        end
    end

    assign o_strobe = r_res.valid;
    assign o_kind = r_res.kind;
    assign o_result_slot = 5'(r_res.slot);
    assign o_result_target = r_res.target;
    assign o_result_data = r_res.data;
    assign o_ok = r_res.ok;
    assign o_last = r_res.last;

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy) else $error("config while busy");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> (r_state == S_IDLE)) else $error("last beat timing");
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy) else $error("beat after end");
    a_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stat[0] == ST_RUN) else $error("sentinel lost");
endmodule
